[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge of clk, except while rst is high.
`define NAFT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check that cond never holds at a rising edge of clk outside reset.
`define NAFT_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define NAFT_ASSERT(lbl, clk, rst, prop)
`define NAFT_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

[design/naft_pkg.sv]
// ----------------------------------------------------------------------------
// naft_pkg
// Shared types, codes and constants of the name/arity function table.
// ----------------------------------------------------------------------------
package naft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_STORE  = 1'b1;

  localparam logic [1:0] STATUS_LOOKUP   = 2'd0;
  localparam logic [1:0] STATUS_UPDATED  = 2'd1;
  localparam logic [1:0] STATUS_INSERTED = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  name_byte;
    logic        has_byte;
    logic        last_byte;
    logic [7:0]  arity;
    logic [63:0] store_value;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] result_value;
    logic [1:0]  status;
  } rsp_t;

  // One table operation, handed from the hashing front to the table back.
  typedef struct packed {
    logic        req_type;
    logic [31:0] key;
    logic [7:0]  arity;
    logic [63:0] store_value;
  } cmd_t;

endpackage

[design/name_arity_function_table.sv]
// ----------------------------------------------------------------------------
// name_arity_function_table
// Function table keyed by an FNV-1a name hash plus an arity.
// ----------------------------------------------------------------------------
// Push one name byte per transfer on req; the transfer that carries last_byte
// completes the key (hash of the name plus arity) and queues one table
// operation, and exactly that transfer later yields one result transfer on
// rsp. Bytes are hashed at one per cycle by the front while the operation
// queue has room. The back handles one operation at a time and walks the
// stored entries in insertion order, reading one stored key per cycle
// through the single read port of the key memory, and stops at the first
// match or after the last stored entry. Lookups return the stored value or
// zero with found low; stores update a matching entry or append, and
// report a full table when TABLE_DEPTH entries are already stored and no
// entry matches. The entry memories need no clearing: only entries below
// the fill count are ever read, so the block takes items from the first
// cycle after reset.
// ----------------------------------------------------------------------------
module name_arity_function_table #(
  parameter int TABLE_DEPTH = naft_pkg::TABLE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  naft_pkg::req_t  req,
  output logic            full,
  input  logic            pop,
  output naft_pkg::rsp_t  rsp,
  output logic            empty
);

  // Front to back: queued table operations.
  logic            cmd_push;
  naft_pkg::cmd_t  cmd_in;
  logic            cmd_full;
  logic            cmd_pop;
  naft_pkg::cmd_t  cmd_out;
  logic            cmd_empty;

  // Back to result queue.
  logic            rsp_push;
  naft_pkg::rsp_t  rsp_in;
  logic            rsp_full;

  // Hash bytes and hand off one operation per completed name.
  naft_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .req      (req),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  // Decouple hashing from the table scan so each side stalls on its own.
  naft_fifo #(
    .DEPTH (naft_pkg::QUEUE_DEPTH),
    .T     (naft_pkg::cmd_t)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Scan, compare and update the entry memories.
  naft_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .rsp_push  (rsp_push),
    .rsp       (rsp_in),
    .rsp_full  (rsp_full)
  );

  // Hold finished results until the consumer takes them.
  naft_fifo #(
    .DEPTH (naft_pkg::QUEUE_DEPTH),
    .T     (naft_pkg::rsp_t)
  ) u_rsp_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rsp_push),
    .wdata (rsp_in),
    .full  (rsp_full),
    .pop   (pop),
    .rdata (rsp),
    .empty (empty)
  );

endmodule

[design/naft_fifo.sv]
// ----------------------------------------------------------------------------
// naft_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module naft_fifo #(
  parameter int  DEPTH = naft_pkg::QUEUE_DEPTH,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

[design/naft_front.sv]
// ----------------------------------------------------------------------------
// naft_front
// Accept name bytes, run the FNV-1a hash, queue one operation per name.
// ----------------------------------------------------------------------------
module naft_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  naft_pkg::req_t  req,
  output logic            full,
  output logic            cmd_push,
  output naft_pkg::cmd_t  cmd,
  input  logic            cmd_full
);

  logic [31:0] hash;
  logic [31:0] mixed;
  logic [31:0] hashed;
  logic [31:0] key;
  logic        accept;

  assign full   = cmd_full;
  assign accept = push && !full;

  assign mixed  = hash ^ {24'd0, req.name_byte};
  assign hashed = mixed * naft_pkg::FNV_PRIME;
  assign key    = req.has_byte ? hashed : hash;

  // Only the final item of a name makes a table operation.
  assign cmd_push        = accept && req.last_byte;
  assign cmd.req_type    = req.req_type;
  assign cmd.key         = key;
  assign cmd.arity       = req.arity;
  assign cmd.store_value = req.store_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= naft_pkg::FNV_BASIS;
    end else if (accept) begin
      hash <= req.last_byte ? naft_pkg::FNV_BASIS : key;
    end
  end

endmodule

[design/naft_back.sv]
// ----------------------------------------------------------------------------
// naft_back
// Scan the entry memory for a key, then look up, update or append.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module naft_back #(
  parameter int TABLE_DEPTH = naft_pkg::TABLE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_empty,
  input  naft_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            rsp_push,
  output naft_pkg::rsp_t  rsp,
  input  logic            rsp_full
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    BK_IDLE  = 4'b0001,
    BK_SCAN  = 4'b0010,
    BK_VALUE = 4'b0100,
    BK_DONE  = 4'b1000
  } back_state_t;

  back_state_t     state;
  naft_pkg::cmd_t  cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_cnt;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  logic [39:0]      key_mem [TABLE_DEPTH];
  logic [63:0]      val_mem [TABLE_DEPTH];
  logic [39:0]      key_rd;
  logic [63:0]      val_rd;

  logic             issue;
  logic [IDX_W-1:0] scan_addr;
  logic [IDX_W-1:0] ins_addr;
  logic             match_now;
  logic             table_full;
  logic             is_lookup;
  logic             rsp_done;
  logic             wr_key;
  logic             wr_val;
  logic [IDX_W-1:0] wr_val_addr;
  logic [1:0]       rsp_status;

  assign issue      = (scan_cnt < count);
  assign scan_addr  = scan_cnt[IDX_W-1:0];
  assign ins_addr   = count[IDX_W-1:0];
  assign match_now  = rd_valid && (key_rd == {cur.arity, cur.key});
  assign table_full = (count == CNT_W'(TABLE_DEPTH));
  assign is_lookup  = (cur.req_type == naft_pkg::REQ_LOOKUP);

  assign cmd_pop  = (state == BK_IDLE) && !cmd_empty;
  assign rsp_done = (state == BK_DONE) && !rsp_full;
  assign rsp_push = rsp_done;

  assign rsp.found        = hit;
  assign rsp.result_value = (is_lookup && hit) ? val_rd : 64'd0;
  assign rsp.status       = rsp_status;
  always_comb begin
    if (is_lookup) begin
      rsp_status = naft_pkg::STATUS_LOOKUP;
    end else if (hit) begin
      rsp_status = naft_pkg::STATUS_UPDATED;
    end else if (table_full) begin
      rsp_status = naft_pkg::STATUS_FULL;
    end else begin
      rsp_status = naft_pkg::STATUS_INSERTED;
    end
  end

  assign wr_key      = rsp_done && !is_lookup && !hit && !table_full;
  assign wr_val      = rsp_done && !is_lookup && (hit || !table_full);
  assign wr_val_addr = hit ? hit_idx : ins_addr;

  always_ff @(posedge clk) begin
    key_rd <= key_mem[scan_addr];
    val_rd <= val_mem[hit_idx];
    if (wr_key) begin
      key_mem[ins_addr] <= {cur.arity, cur.key};
    end
    if (wr_val) begin
      val_mem[wr_val_addr] <= cur.store_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      count    <= '0;
      scan_cnt <= '0;
      rd_valid <= 1'b0;
      hit      <= 1'b0;
    end else begin
      // Tag the key read issued this cycle; drop it once a match is seen.
      rd_valid <= (state == BK_SCAN) && issue && !match_now;
      rd_idx   <= scan_addr;
      case (state)
        BK_IDLE: begin
          if (!cmd_empty) begin
            cur      <= cmd;
            scan_cnt <= '0;
            hit      <= 1'b0;
            state    <= BK_SCAN;
          end
        end
        BK_SCAN: begin
          if (match_now) begin
            hit     <= 1'b1;
            hit_idx <= rd_idx;
            state   <= is_lookup ? BK_VALUE : BK_DONE;
          end else if (!issue && !rd_valid) begin
            state <= BK_DONE;
          end else if (issue) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        BK_VALUE: begin
          state <= BK_DONE;
        end
        BK_DONE: begin
          if (!rsp_full) begin
            if (wr_key) begin
              count <= count + 1'b1;
            end
            state <= BK_IDLE;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

  `NAFT_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(TABLE_DEPTH))
  `NAFT_ASSERT(a_count_only_done, clk, rst, (state != BK_DONE) |=> (count == $past(count)))
  `NAFT_ASSERT(a_read_from_scan, clk, rst, rd_valid |-> ($past(state) == BK_SCAN))
  `NAFT_ASSERT_NEVER(a_hit_beyond_count, clk, rst,
    (state == BK_DONE) && hit && (CNT_W'(hit_idx) >= count))

endmodule

[tb/tb_name_arity_function_table.sv]
// ----------------------------------------------------------------------------
// tb_name_arity_function_table
// Self-checking bench for the hashed name/arity function table: a directed
// script of corner cases, then random well-formed names mostly drawn from a
// shared pool so lookups hit, stores update and the table runs full. Every
// result is compared field by field to a local table model or typed result.
// ----------------------------------------------------------------------------
module tb_name_arity_function_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] HASH_SEED = 32'd2166136261;
  localparam logic [31:0] HASH_MULT = 32'd16777619;

  localparam int ITEMS_TOTAL     = 1550;
  localparam int POOL_SIZE       = 96;   // more names than table slots, so it fills
  localparam int MAX_NAME        = 12;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = naft_pkg::TABLE_DEPTH + 16;
  localparam int REPORT_LIMIT    = 10;

  typedef struct {
    naft_pkg::req_t item;
    bit             typed;   // expected result typed in below rather than predicted
    naft_pkg::rsp_t want;
  } script_row_t;

  logic           clk   = 1'b0;
  logic           rst   = 1'b1;
  logic           push  = 1'b0;
  naft_pkg::req_t req   = '0;
  logic           pop   = 1'b0;
  logic           full;
  logic           empty;
  naft_pkg::rsp_t rsp;

  // Table model state: running name hash plus the stored entries in order.
  logic [31:0] name_hash = HASH_SEED;
  int          entries_used = 0;
  logic [31:0] entry_key   [naft_pkg::TABLE_DEPTH];
  logic [7:0]  entry_arity [naft_pkg::TABLE_DEPTH];
  logic [63:0] entry_value [naft_pkg::TABLE_DEPTH];

  naft_pkg::rsp_t rsp_due [$];  // results owed by the block, oldest first
  int   mismatches    = 0;
  int   items_sent    = 0;  // name-bearing transfers; ignored fillers excluded
  int   stall_cycles  = 0;
  int   feed_idle_pct  = 8;
  int   drain_idle_pct = 53;
  bit   hold_off_req  = 1'b0;
  bit   hold_off_done = 1'b0;

  script_row_t script [$];

  logic [7:0] pool_text  [POOL_SIZE][MAX_NAME];
  int         pool_len   [POOL_SIZE];
  logic [7:0] pool_arity [POOL_SIZE];

  name_arity_function_table dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .req   (req),
    .full  (full),
    .pop   (pop),
    .rsp   (rsp),
    .empty (empty)
  );

  always #6 clk = ~clk;

  function automatic naft_pkg::req_t mk(logic op, logic [7:0] b, logic hb, logic lb,
                                        logic [7:0] ar, logic [63:0] v);
    naft_pkg::req_t r;
    r.req_type    = op;
    r.name_byte   = b;
    r.has_byte    = hb;
    r.last_byte   = lb;
    r.arity       = ar;
    r.store_value = v;
    return r;
  endfunction

  function automatic naft_pkg::rsp_t rs(logic f, logic [63:0] v, logic [1:0] s);
    naft_pkg::rsp_t r;
    r.found        = f;
    r.result_value = v;
    r.status       = s;
    return r;
  endfunction

  function automatic script_row_t row(naft_pkg::req_t item, bit typed = 1'b0,
                                      naft_pkg::rsp_t want = '0);
    script_row_t r;
    r.item  = item;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Mostly full-range values, with the two extremes mixed in.
  function automatic logic [63:0] rand_value();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 64'd0;
    if (k == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Advance the model by one accepted transfer: fold in the byte, and on the
  // final transfer of a name run the table operation and produce its result.
  task automatic predict_table_op(input naft_pkg::req_t item, output bit gives,
                                  output naft_pkg::rsp_t out);
    logic [31:0] key;
    int          hit;
    out   = '0;
    gives = 1'b0;
    if (item.has_byte)
      name_hash = (name_hash ^ {24'd0, item.name_byte}) * HASH_MULT;
    if (!item.last_byte)
      return;
    key       = name_hash;
    name_hash = HASH_SEED;
    gives     = 1'b1;
    hit       = -1;
    // First match in insertion order wins.
    for (int i = 0; i < entries_used; i++) begin
      if (hit < 0 && entry_key[i] == key && entry_arity[i] == item.arity)
        hit = i;
    end
    if (item.req_type == naft_pkg::REQ_LOOKUP) begin
      out.status = naft_pkg::STATUS_LOOKUP;
      if (hit >= 0) begin
        out.found        = 1'b1;
        out.result_value = entry_value[hit];
      end
    end else if (hit >= 0) begin
      entry_value[hit] = item.store_value;
      out.found        = 1'b1;
      out.status       = naft_pkg::STATUS_UPDATED;
    end else if (entries_used < naft_pkg::TABLE_DEPTH) begin
      entry_key[entries_used]   = key;
      entry_arity[entries_used] = item.arity;
      entry_value[entries_used] = item.store_value;
      entries_used++;
      out.status = naft_pkg::STATUS_INSERTED;
    end else begin
      out.status = naft_pkg::STATUS_FULL;
    end
  endtask

  // Offer one item, holding it until the block takes it, then log what the
  // block now owes. Sender idle gaps are inserted ahead of the item.
  task automatic send(input naft_pkg::req_t item, input bit typed,
                      input naft_pkg::rsp_t want);
    bit             gives;
    naft_pkg::rsp_t pred;
    while ($urandom_range(99) < feed_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    req  <= item;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_table_op(item, gives, pred);
    if (gives)
      rsp_due.push_back(typed ? want : pred);
    if (item.has_byte || item.last_byte)
      items_sent++;
  endtask

  // Stream one name: its bytes, occasional ignored fillers, then the final
  // transfer that carries the operation. The last byte rides on the final
  // transfer about half of the time.
  task automatic send_name(input int len, input logic [7:0] text [MAX_NAME],
                           input logic op, input logic [7:0] ar, input logic [63:0] val);
    bit fold;
    int body;
    fold = (len > 0) && ($urandom_range(1) == 1);
    body = fold ? len - 1 : len;
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(9) == 0)
        send(mk(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0,
                8'($urandom_range(255)), rand_value()), 1'b0, '0);
      send(mk(1'($urandom_range(1)), text[i], 1'b1, 1'b0, 8'($urandom_range(255)),
              rand_value()), 1'b0, '0);
    end
    send(mk(op, fold ? text[len - 1] : 8'($urandom_range(255)), fold, 1'b1, ar, val),
         1'b0, '0);
  endtask

  task automatic note_mismatch(input string what, input naft_pkg::rsp_t want,
                               input naft_pkg::rsp_t got);
    if (mismatches < REPORT_LIMIT)
      $display("%t %s: found exp %0b got %0b, value exp %h got %h, status exp %0d got %0d",
               $realtime, what, want.found, got.found, want.result_value,
               got.result_value, want.status, got.status);
    mismatches++;
  endtask

  // Result checker: every popped result must match the oldest one owed.
  always @(posedge clk) begin : check_results
    naft_pkg::rsp_t want;
    if (!rst && pop && !empty) begin
      if (rsp_due.size() == 0) begin
        note_mismatch("result with nothing owed", '0, rsp);
      end else begin
        want = rsp_due.pop_front();
        if (rsp.found !== want.found || rsp.result_value !== want.result_value ||
            rsp.status !== want.status)
          note_mismatch("result mismatch", want, rsp);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: random pop stalls per phase, plus one long hold-off so the
  // block backs up and drops full while the sender keeps offering.
  initial begin : drain
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        pop <= 1'b0;
        hold_off_done = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= drain_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] text [MAX_NAME];
    int         pick;
    int         len;
    logic [7:0] ar;
    logic       op;

    // Empty name against an empty table, then insert, hit and arity miss.
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h00, 1'b0, 1'b1, 8'd0, 64'd0),
                         1'b1, rs(1'b0, 64'd0, naft_pkg::STATUS_LOOKUP)));
    script.push_back(row(mk(naft_pkg::REQ_STORE, 8'hA5, 1'b0, 1'b1, 8'd0, '1),
                         1'b1, rs(1'b0, 64'd0, naft_pkg::STATUS_INSERTED)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h00, 1'b0, 1'b1, 8'd0, 64'd0),
                         1'b1, rs(1'b1, '1, naft_pkg::STATUS_LOOKUP)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h00, 1'b0, 1'b1, 8'd255, '1),
                         1'b1, rs(1'b0, 64'd0, naft_pkg::STATUS_LOOKUP)));
    // Two-byte name, second byte on the final transfer, top arity, zero value.
    script.push_back(row(mk(naft_pkg::REQ_STORE, 8'hFF, 1'b1, 1'b0, 8'hFF, '1)));
    script.push_back(row(mk(naft_pkg::REQ_STORE, 8'h00, 1'b1, 1'b1, 8'hFF, 64'd0),
                         1'b1, rs(1'b0, 64'd0, naft_pkg::STATUS_INSERTED)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'hFF, 1'b1, 1'b0, 8'h00, 64'd0)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h00, 1'b1, 1'b1, 8'hFF, '1),
                         1'b1, rs(1'b1, 64'd0, naft_pkg::STATUS_LOOKUP)));
    // Update the empty-name entry and read it back.
    script.push_back(row(mk(naft_pkg::REQ_STORE, 8'h00, 1'b0, 1'b1, 8'd0,
                            64'h0123_4567_89AB_CDEF),
                         1'b1, rs(1'b1, 64'd0, naft_pkg::STATUS_UPDATED)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h00, 1'b0, 1'b1, 8'd0, 64'd0),
                         1'b1, rs(1'b1, 64'h0123_4567_89AB_CDEF, naft_pkg::STATUS_LOOKUP)));
    // Name with an ignored filler in the middle.
    script.push_back(row(mk(naft_pkg::REQ_STORE, 8'h61, 1'b1, 1'b0, 8'd9, 64'd5)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h3C, 1'b0, 1'b0, 8'd1, '1)));
    script.push_back(row(mk(naft_pkg::REQ_STORE, 8'h62, 1'b1, 1'b1, 8'd3,
                            64'h8000_0000_0000_0001),
                         1'b1, rs(1'b0, 64'd0, naft_pkg::STATUS_INSERTED)));
    // Same name: byteless final with wrong arity, then final with byte and right arity.
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h61, 1'b1, 1'b0, 8'd0, 64'd0)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h62, 1'b1, 1'b0, 8'd0, 64'd0)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h00, 1'b0, 1'b1, 8'd4, 64'd0),
                         1'b1, rs(1'b0, 64'd0, naft_pkg::STATUS_LOOKUP)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h61, 1'b1, 1'b0, 8'd0, 64'd0)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h62, 1'b1, 1'b1, 8'd3, 64'd0)));
    // Single high byte, mid arity: insert, then store again as an update.
    script.push_back(row(mk(naft_pkg::REQ_STORE, 8'h80, 1'b1, 1'b1, 8'd128,
                            64'hDEAD_BEEF_0000_FFFF)));
    script.push_back(row(mk(naft_pkg::REQ_STORE, 8'h80, 1'b1, 1'b1, 8'd128,
                            64'h5555_AAAA_5555_AAAA)));
    script.push_back(row(mk(naft_pkg::REQ_LOOKUP, 8'h80, 1'b1, 1'b1, 8'd128, 64'd0)));

    // Name pool; some entries reuse the previous name under another arity.
    for (int p = 0; p < POOL_SIZE; p++) begin
      if (p > 0 && $urandom_range(3) == 0) begin
        pool_len[p]  = pool_len[p - 1];
        pool_text[p] = pool_text[p - 1];
      end else begin
        pool_len[p] = ($urandom_range(9) == 0) ? $urandom_range(5, MAX_NAME)
                                               : $urandom_range(0, 4);
        for (int i = 0; i < MAX_NAME; i++)
          pool_text[p][i] = 8'($urandom_range(255));
      end
      case ($urandom_range(9))
        0:       pool_arity[p] = 8'd0;
        1:       pool_arity[p] = 8'd255;
        default: pool_arity[p] = 8'($urandom_range(255));
      endcase
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send(script[i].item, script[i].typed, script[i].want);

    // Random names: mostly from the pool, some fresh; idle pattern shifts
    // by thirds, with the long receiver hold-off in the no-idle stretch.
    while (items_sent < ITEMS_TOTAL) begin
      if (items_sent >= 2 * ITEMS_TOTAL / 3) begin
        feed_idle_pct  = 0;
        drain_idle_pct = 0;
        hold_off_req   = 1'b1;
      end else if (items_sent >= ITEMS_TOTAL / 3) begin
        feed_idle_pct  = 53;
        drain_idle_pct = 8;
      end
      op = $urandom_range(1) ? naft_pkg::REQ_STORE : naft_pkg::REQ_LOOKUP;
      if ($urandom_range(99) < 85) begin
        pick = $urandom_range(POOL_SIZE - 1);
        len  = pool_len[pick];
        text = pool_text[pick];
        ar   = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : pool_arity[pick];
      end else begin
        len = $urandom_range(0, 6);
        for (int i = 0; i < MAX_NAME; i++)
          text[i] = 8'($urandom_range(255));
        ar = 8'($urandom_range(255));
      end
      send_name(len, text, op, ar, rand_value());
    end
    push <= 1'b0;

    // Drain everything owed, then leave room for any stray result.
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && rsp_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
